[sv/ccbz_pkg.sv]
// ccbz_pkg: shared types and constants of the cubic bezier path sampler
// no dependencies; used by every module of the block except ccbz_ram
`default_nettype none

package ccbz_pkg;

   localparam int POINT_CAPACITY_DEF = 64;
   localparam int SAMPLE_LIMIT_DEF   = 64;
   localparam int MIN_SAMPLES        = 4;
   localparam int SAMPLE_COUNT_W     = 7;
   localparam int COORD_W            = 32;
   localparam int WEIGHT_W           = 17;
   localparam int DIV_STEPS          = 17;
   localparam logic [SAMPLE_COUNT_W-1:0] SAMPLE_COUNT_RESET = 7'd16;
   localparam logic [WEIGHT_W-1:0]       ONE_Q16            = 17'h10000;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic                      final_point;
   } req_item_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic                      run_end;
      logic                      bad_spline;
   } rsp_item_type;

   typedef struct packed {
      logic       load;
      logic       init_run;
      logic       seg_sub;
      logic       div_step;
      logic       div_first;
      logic       mul1;
      logic       mul2;
      logic       mul3;
      logic       acc_clr;
      logic       rd;
      logic [1:0] rd_j;
      logic       emit_ok;
      logic       emit_bad;
      logic       next_sample;
   } dp_cmd_type;

   typedef struct packed {
      logic spline_ok;
      logic seg_more;
      logic last_sample;
   } dp_status_type;

endpackage

`default_nettype wire

[sv/cubic_bezier_path_sampler.sv]
// cubic_bezier_path_sampler: top level, joins controller and datapath
// depends on ccbz_pkg, ccbz_ctrl, ccbz_dp (and through it ccbz_ram)
//
// Usage:
//   Control points enter on req_item when start is high and busy is low, one
//   per cycle while loading. The point with final_point set closes the
//   spline. A spline of 3k+1 points (k >= 1, within capacity) is sampled at
//   max(4, sample_count) points, capped at SAMPLE_LIMIT; any other spline
//   yields one item with bad_spline and run_end set and zero coordinates.
//   Each result shows on rsp_item for one cycle with rsp_strobe; the
//   receiver must take it then. run_end marks the last item of a run.
//   sample_count is written on csr_data with csr_valid/csr_ready; csr_ready
//   is high whenever busy is low.
// Sequence:
//   a bad spline gives its item from state ST_BAD, once the final point is taken.
//   A valid spline is worked one sample at a time by the segment walk, the
//   restoring divider, three weight multiply steps and four point store
//   reads; busy stays high until the last item of the run is shown.
// Reset: synchronous; clears the point count and sets sample_count to 16.
//   Point stores are not cleared; only points of the current spline are read.
`default_nettype none

module cubic_bezier_path_sampler #(
   parameter int POINT_CAPACITY = ccbz_pkg::POINT_CAPACITY_DEF,
   parameter int SAMPLE_LIMIT   = ccbz_pkg::SAMPLE_LIMIT_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire ccbz_pkg::req_item_type              req_item,
   output logic                                     rsp_strobe,
   output ccbz_pkg::rsp_item_type                   rsp_item,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ccbz_pkg::SAMPLE_COUNT_W-1:0] csr_data
);

   ccbz_pkg::dp_cmd_type    cmd;
   ccbz_pkg::dp_status_type status;

   ccbz_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_final  (req_item.final_point),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .csr_ready  (csr_ready),
      .rsp_strobe (rsp_strobe)
   );

   ccbz_dp #(
      .POINT_CAPACITY (POINT_CAPACITY),
      .SAMPLE_LIMIT   (SAMPLE_LIMIT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

[sv/ccbz_ram.sv]
// ccbz_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ccbz_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[sv/ccbz_ctrl.sv]
// ccbz_ctrl: sequencing state machine of the sampler
// depends on ccbz_pkg; drives ccbz_dp through command and status structs
`default_nettype none

module ccbz_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic                   req_final,
   input  wire ccbz_pkg::dp_status_type status,
   output ccbz_pkg::dp_cmd_type         cmd,
   output logic                        busy,
   output logic                        csr_ready,
   output logic                        rsp_strobe
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_BAD, ST_SEG, ST_DIV, ST_MUL1, ST_MUL2, ST_MUL3, ST_RD, ST_ACC, ST_EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       strobe_ff, strobe_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      strobe_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
            if (start && req_final) begin
               if (status.spline_ok) begin
                  cmd.init_run = 1'b1;
                  state_in     = ST_SEG;
               end else begin
                  state_in = ST_BAD;
               end
            end
         end
         ST_BAD: begin
            cmd.emit_bad = 1'b1;
            strobe_in    = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SEG: begin
            if (status.seg_more) begin
               cmd.seg_sub = 1'b1;
            end else begin
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = (cnt_ff == '0);
            if (cnt_ff == 5'(ccbz_pkg::DIV_STEPS - 1)) begin
               state_in = ST_MUL1;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.mul3    = 1'b1;
            cmd.acc_clr = 1'b1;
            cnt_in      = '0;
            state_in    = ST_RD;
         end
         ST_RD: begin
            cmd.rd   = 1'b1;
            cmd.rd_j = cnt_ff[1:0];
            if (cnt_ff[1:0] == 2'd3) begin
               state_in = ST_ACC;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ST_ACC: begin
            // last control point lands in the accumulator here
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit_ok = 1'b1;
            strobe_in   = 1'b1;
            if (status.last_sample) begin
               state_in = ST_IDLE;
            end else begin
               cmd.next_sample = 1'b1;
               state_in        = ST_SEG;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

`default_nettype wire

[sv/ccbz_dp.sv]
// ccbz_dp: point stores, segment tracking, divider, weight and mix datapath
// depends on ccbz_pkg and ccbz_ram; commanded by ccbz_ctrl
`default_nettype none

module ccbz_dp #(
   parameter int POINT_CAPACITY = ccbz_pkg::POINT_CAPACITY_DEF,
   parameter int SAMPLE_LIMIT   = ccbz_pkg::SAMPLE_LIMIT_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire ccbz_pkg::dp_cmd_type                 cmd,
   output ccbz_pkg::dp_status_type                   status,
   input  wire ccbz_pkg::req_item_type               req_item,
   input  wire logic                                 csr_valid,
   input  wire logic                                 csr_ready,
   input  wire logic [ccbz_pkg::SAMPLE_COUNT_W-1:0]  csr_data,
   output ccbz_pkg::rsp_item_type                    rsp_item
);

   localparam int AW  = $clog2(POINT_CAPACITY);
   localparam int CW  = $clog2(POINT_CAPACITY + 1);
   localparam int DW  = $clog2(SAMPLE_LIMIT);
   localparam int RW  = ((DW > CW) ? DW : CW) + 1;
   localparam int WW  = ccbz_pkg::WEIGHT_W;
   localparam int SCW = ccbz_pkg::SAMPLE_COUNT_W;

   // point loading
   logic [CW-1:0] loaded_ff, loaded_in, segs_ff, segs_in, segs_cnt;
   logic [1:0]    ph_ff, ph_in;
   logic          ovf_ff, ovf_in, wr_en, ok_calc;

   always_comb begin
      loaded_in = loaded_ff;
      segs_in   = segs_ff;
      ph_in     = ph_ff;
      ovf_in    = ovf_ff;
      wr_en     = 1'b0;
      if (cmd.load) begin
         if (loaded_ff == CW'(POINT_CAPACITY)) begin
            ovf_in = 1'b1;
         end else begin
            wr_en     = 1'b1;
            loaded_in = loaded_ff + 1'b1;
            // track (count - 1) as 3 * segs + ph
            if (loaded_ff != '0) begin
               if (ph_ff == 2'd2) begin
                  ph_in   = 2'd0;
                  segs_in = segs_ff + 1'b1;
               end else begin
                  ph_in = ph_ff + 2'd1;
               end
            end
         end
      end
      // segment count of the spline closed by this item, before the counters clear
      segs_cnt = segs_in;
      ok_calc  = !ovf_in && (segs_in != '0) && (ph_in == 2'd0);
      if (cmd.load && req_item.final_point) begin
         loaded_in = '0;
         segs_in   = '0;
         ph_in     = '0;
         ovf_in    = 1'b0;
      end
   end

   assign status.spline_ok = ok_calc;

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
         segs_ff   <= '0;
         ph_ff     <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         loaded_ff <= loaded_in;
         segs_ff   <= segs_in;
         ph_ff     <= ph_in;
         ovf_ff    <= ovf_in;
      end
   end

   // sample count register and clamp
   logic [SCW-1:0] sc_ff, samp;
   logic [DW-1:0]  den_calc;

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff <= ccbz_pkg::SAMPLE_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         sc_ff <= csr_data;
      end
   end

   always_comb begin
      if (sc_ff < SCW'(ccbz_pkg::MIN_SAMPLES)) begin
         samp = SCW'(ccbz_pkg::MIN_SAMPLES);
      end else if (sc_ff > SCW'(SAMPLE_LIMIT)) begin
         samp = SCW'(SAMPLE_LIMIT);
      end else begin
         samp = sc_ff;
      end
      den_calc = DW'(samp - 1'b1);
   end

   // segment walk: seg and rem follow i * segs = seg * den + rem
   logic [DW-1:0] den_ff, i_ff;
   logic [CW-1:0] seg_ff, run_segs_ff;
   logic [RW-1:0] rem_ff;

   always_ff @(posedge clock) begin
      if (cmd.init_run) begin
         den_ff      <= den_calc;
         run_segs_ff <= segs_cnt;
         i_ff        <= '0;
         seg_ff      <= '0;
         rem_ff      <= '0;
      end else if (cmd.seg_sub) begin
         rem_ff <= rem_ff - RW'(den_ff);
         seg_ff <= seg_ff + 1'b1;
      end else if (cmd.next_sample) begin
         i_ff   <= i_ff + 1'b1;
         rem_ff <= rem_ff + RW'(run_segs_ff);
      end
   end

   assign status.seg_more    = (rem_ff >= RW'(den_ff)) &&
                               (({1'b0, seg_ff} + 1'b1) < {1'b0, run_segs_ff});
   assign status.last_sample = (i_ff == den_ff);

   // restoring divider: s = (rem << 16) / den, one quotient bit a cycle
   logic [DW-1:0] r_ff;
   logic [DW:0]   r_sh;
   logic [WW-1:0] q_ff;
   logic          r_ge;

   assign r_sh = cmd.div_first ? {1'b0, rem_ff[DW-1:0]} : {r_ff, 1'b0};
   assign r_ge = (r_sh >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_step) begin
         r_ff <= r_ge ? DW'(r_sh - {1'b0, den_ff}) : r_sh[DW-1:0];
         q_ff <= {q_ff[WW-2:0], r_ge};
      end
   end

   // bernstein weights
   logic [WW-1:0]     u_val;
   logic [2*WW-1:0]   u2_ff, s2_ff;
   logic [3*WW-1:0]   t0_ff, t1_ff, t2_ff;
   logic [3*WW+1:0]   t1x3, t2x3;
   logic [WW-1:0]     w_ff [4];
   logic [WW-1:0]     w0, w1, w2;

   assign u_val = ccbz_pkg::ONE_Q16 - q_ff;
   assign t1x3  = {2'b0, t1_ff} + {1'b0, t1_ff, 1'b0};
   assign t2x3  = {2'b0, t2_ff} + {1'b0, t2_ff, 1'b0};
   assign w0    = t0_ff[32+WW-1:32];
   assign w1    = t1x3[32+WW-1:32];
   assign w2    = t2x3[32+WW-1:32];

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         u2_ff <= u_val * u_val;
         s2_ff <= q_ff * q_ff;
      end
      if (cmd.mul2) begin
         t0_ff <= u2_ff * u_val;
         t1_ff <= u2_ff * q_ff;
         t2_ff <= s2_ff * u_val;
      end
      if (cmd.mul3) begin
         w_ff[0] <= w0;
         w_ff[1] <= w1;
         w_ff[2] <= w2;
         w_ff[3] <= ccbz_pkg::ONE_Q16 - w0 - w1 - w2;
      end
   end

   // point stores
   logic [CW+1:0]                 base;
   logic [AW-1:0]                 raddr;
   logic [ccbz_pkg::COORD_W-1:0]  rd_x, rd_y, rd_z;

   assign base  = {1'b0, seg_ff, 1'b0} + {2'b0, seg_ff};
   assign raddr = AW'(base + (CW+2)'(cmd.rd_j));

   ccbz_ram #(.WIDTH(ccbz_pkg::COORD_W), .DEPTH(POINT_CAPACITY)) u_ram_x (
      .clock (clock), .we (wr_en), .waddr (loaded_ff[AW-1:0]),
      .wdata (req_item.point_x), .raddr (raddr), .rdata (rd_x)
   );
   ccbz_ram #(.WIDTH(ccbz_pkg::COORD_W), .DEPTH(POINT_CAPACITY)) u_ram_y (
      .clock (clock), .we (wr_en), .waddr (loaded_ff[AW-1:0]),
      .wdata (req_item.point_y), .raddr (raddr), .rdata (rd_y)
   );
   ccbz_ram #(.WIDTH(ccbz_pkg::COORD_W), .DEPTH(POINT_CAPACITY)) u_ram_z (
      .clock (clock), .we (wr_en), .waddr (loaded_ff[AW-1:0]),
      .wdata (req_item.point_z), .raddr (raddr), .rdata (rd_z)
   );

   // weighted mix, one control point a cycle
   logic                 rd_dly_ff;
   logic [1:0]           j_dly_ff;
   logic [WW-1:0]        w_sel;
   logic signed [49:0]   prod_x, prod_y, prod_z;
   logic signed [50:0]   acc_x_ff, acc_y_ff, acc_z_ff;

   assign w_sel  = w_ff[j_dly_ff];
   assign prod_x = $signed({1'b0, w_sel}) * $signed(rd_x);
   assign prod_y = $signed({1'b0, w_sel}) * $signed(rd_y);
   assign prod_z = $signed({1'b0, w_sel}) * $signed(rd_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_dly_ff <= 1'b0;
      end else begin
         rd_dly_ff <= cmd.rd;
      end
      j_dly_ff <= cmd.rd_j;
      if (cmd.acc_clr) begin
         acc_x_ff <= '0;
         acc_y_ff <= '0;
         acc_z_ff <= '0;
      end else if (rd_dly_ff) begin
         acc_x_ff <= acc_x_ff + 51'(prod_x);
         acc_y_ff <= acc_y_ff + 51'(prod_y);
         acc_z_ff <= acc_z_ff + 51'(prod_z);
      end
   end

   // result register; the arithmetic shift floors negative sums
   ccbz_pkg::rsp_item_type out_ff;

   always_ff @(posedge clock) begin
      if (cmd.emit_ok) begin
         out_ff.out_x      <= acc_x_ff[47:16];
         out_ff.out_y      <= acc_y_ff[47:16];
         out_ff.out_z      <= acc_z_ff[47:16];
         out_ff.run_end    <= status.last_sample;
         out_ff.bad_spline <= 1'b0;
      end else if (cmd.emit_bad) begin
         out_ff.out_x      <= '0;
         out_ff.out_y      <= '0;
         out_ff.out_z      <= '0;
         out_ff.run_end    <= 1'b1;
         out_ff.bad_spline <= 1'b1;
      end
   end

   assign rsp_item = out_ff;

endmodule

`default_nettype wire

[sv/ccbz_checker.sv]
// ccbz_checker: port level assertions for cubic_bezier_path_sampler
// depends on ccbz_pkg; bound to the top level below
`default_nettype none

module ccbz_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire ccbz_pkg::req_item_type req_item,
   input wire logic                   rsp_strobe,
   input wire ccbz_pkg::rsp_item_type rsp_item,
   input wire logic                   csr_ready
);

   // a rejected spline always closes its run
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.bad_spline |-> rsp_item.run_end)
      else $error("bad item without run_end");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.bad_spline |->
         rsp_item.out_x == '0 && rsp_item.out_y == '0 && rsp_item.out_z == '0)
      else $error("bad item with nonzero coordinates");

   // a point that does not end the spline makes no result
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_item.final_point |=> !rsp_strobe)
      else $error("result after a non-final point");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.run_end |=> !rsp_strobe)
      else $error("result right after end of run");

   assert property (@(posedge clock) disable iff (reset)
      !busy |-> csr_ready)
      else $error("csr not ready while idle");

endmodule

bind cubic_bezier_path_sampler ccbz_checker u_ccbz_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item),
   .csr_ready  (csr_ready)
);

`default_nettype wire

[test/tb.sv]
// tb: self-checking bench for cubic_bezier_path_sampler
// depends on ccbz_pkg and the sampler rtl; drives control points, predicts samples
`default_nettype none

module tb;

   localparam int CAP = ccbz_pkg::POINT_CAPACITY_DEF;
   localparam int LIM = ccbz_pkg::SAMPLE_LIMIT_DEF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   ccbz_pkg::req_item_type req_item = '0;
   logic rsp_strobe;
   ccbz_pkg::rsp_item_type rsp_item;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [ccbz_pkg::SAMPLE_COUNT_W-1:0] csr_data = '0;

   cubic_bezier_path_sampler dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // predictor state
   logic signed [31:0] pts_x [CAP];
   logic signed [31:0] pts_y [CAP];
   logic signed [31:0] pts_z [CAP];
   int unsigned n_loaded = 0;
   bit store_overflow = 0;
   int unsigned samples_req = 16;

   ccbz_pkg::req_item_type pending_points [$];
   ccbz_pkg::rsp_item_type expected_samples [$];
   int errors = 0;
   int send_idle_pct = 0;
   bit in_flight = 0;
   bit stim_done = 0;

   task automatic report_mismatch(input string what);
      $display("error at %0t: %s", $realtime, what);
      errors++;
   endtask

   function automatic logic signed [31:0] blend(input logic signed [31:0] p0,
      input logic signed [31:0] p1, input logic signed [31:0] p2,
      input logic signed [31:0] p3, input longint w0, input longint w1,
      input longint w2, input longint w3);
      longint acc;
      acc = w0 * longint'(p0) + w1 * longint'(p1) + w2 * longint'(p2)
            + w3 * longint'(p3);
      return 32'(acc >>> 16);  // arithmetic shift is floor
   endfunction

   task automatic predict_point(input ccbz_pkg::req_item_type it);
      int unsigned segs, ns, den, num, seg, b;
      longint unsigned s, u, w0, w1, w2, w3;
      ccbz_pkg::rsp_item_type r;
      if (n_loaded < CAP) begin
         pts_x[n_loaded] = it.point_x;
         pts_y[n_loaded] = it.point_y;
         pts_z[n_loaded] = it.point_z;
         n_loaded++;
      end else
         store_overflow = 1;
      if (!it.final_point) return;
      if (store_overflow || n_loaded < 4 || (n_loaded - 1) % 3 != 0) begin
         r = '0;
         r.run_end = 1'b1;
         r.bad_spline = 1'b1;
         expected_samples = {expected_samples, r};
      end else begin
         segs = (n_loaded - 1) / 3;
         ns = samples_req < ccbz_pkg::MIN_SAMPLES ? ccbz_pkg::MIN_SAMPLES : samples_req;
         if (ns > LIM) ns = LIM;
         den = ns - 1;
         for (int i = 0; i < ns; i++) begin
            num = i * segs;
            seg = num / den;
            if (seg > segs - 1) seg = segs - 1;
            s = ((longint'(num - seg * den)) << 16) / den;
            u = 65536 - s;
            w0 = (u * u * u) >> 32;
            w1 = (3 * u * u * s) >> 32;
            w2 = (3 * u * s * s) >> 32;
            w3 = 65536 - w0 - w1 - w2;
            b = seg * 3;
            r.out_x = blend(pts_x[b], pts_x[b+1], pts_x[b+2], pts_x[b+3],
                            w0, w1, w2, w3);
            r.out_y = blend(pts_y[b], pts_y[b+1], pts_y[b+2], pts_y[b+3],
                            w0, w1, w2, w3);
            r.out_z = blend(pts_z[b], pts_z[b+1], pts_z[b+2], pts_z[b+3],
                            w0, w1, w2, w3);
            r.run_end = (i == ns - 1);
            r.bad_spline = 1'b0;
            expected_samples = {expected_samples, r};
         end
      end
      n_loaded = 0;
      store_overflow = 0;
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_point(req_item);
            void'(pending_points.pop_front());
         end
         if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            start <= 1'b1;
            req_item <= pending_points[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_samples.size() == 0)
            report_mismatch("sample with nothing expected");
         else begin
            ccbz_pkg::rsp_item_type e;
            e = expected_samples.pop_front();
            if (rsp_item.out_x !== e.out_x)
               report_mismatch($sformatf("out_x %h exp %h", rsp_item.out_x, e.out_x));
            if (rsp_item.out_y !== e.out_y)
               report_mismatch($sformatf("out_y %h exp %h", rsp_item.out_y, e.out_y));
            if (rsp_item.out_z !== e.out_z)
               report_mismatch($sformatf("out_z %h exp %h", rsp_item.out_z, e.out_z));
            if (rsp_item.run_end !== e.run_end)
               report_mismatch($sformatf("run_end %b exp %b", rsp_item.run_end, e.run_end));
            if (rsp_item.bad_spline !== e.bad_spline)
               report_mismatch($sformatf("bad_spline %b exp %b",
                                         rsp_item.bad_spline, e.bad_spline));
         end
      end
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(1) ? 32'hffffffff : 32'h0;
         3: return 32'($signed($urandom_range(400000)) - 200000);
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_spline(input int n, input bit extremes);
      ccbz_pkg::req_item_type it;
      for (int i = 0; i < n; i++) begin
         it.point_x = extremes ? ((i % 2) ? 32'h7fffffff : 32'h80000000) : rand_coord();
         it.point_y = extremes ? ((i % 2) ? 32'h80000000 : 32'h7fffffff) : rand_coord();
         it.point_z = extremes ? 32'hffffffff : rand_coord();
         it.final_point = (i == n - 1);
         pending_points = {pending_points, it};
      end
   endtask

   task automatic wait_drained();
      while (pending_points.size() > 0 || start || expected_samples.size() > 0 || busy)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_samples(input int v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= ccbz_pkg::SAMPLE_COUNT_W'(v);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      samples_req = v;
   endtask

   task automatic random_phase(input int points_goal);
      int sent;
      int n;
      sent = 0;
      while (sent < points_goal) begin
         if ($urandom_range(9) < 8)
            n = 3 * $urandom_range(1, 6) + 1;
         else if ($urandom_range(9) == 0)
            n = CAP + $urandom_range(1, 3);
         else
            n = $urandom_range(1, 12);
         queue_spline(n, 0);
         sent += n;
         while (pending_points.size() > 8) @(posedge clock);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: reset sample count, extremes, bad lengths, overflow, full store
      send_idle_pct = 36;
      queue_spline(4, 1);
      queue_spline(1, 0);
      queue_spline(3, 0);
      queue_spline(5, 0);
      queue_spline(7, 1);
      wait_drained();
      write_samples(0);
      queue_spline(4, 0);
      wait_drained();
      write_samples(127);
      queue_spline(CAP + 1, 0);
      queue_spline(7, 0);
      wait_drained();
      write_samples(64);
      queue_spline(CAP, 0);
      wait_drained();
      write_samples(5);
      queue_spline(10, 0);
      wait_drained();

      random_phase(30);
      wait_drained();
      send_idle_pct = 79;
      write_samples($urandom_range(4, 20));
      random_phase(30);
      wait_drained();
      send_idle_pct = 0;
      write_samples($urandom_range(0, 3));
      random_phase(20);
      wait_drained();
      write_samples(2 + $urandom_range(30));
      random_phase(20);
      wait_drained();

      if (errors == 0)
         $display("cubic_bezier_path_sampler: match");
      else
         $display("cubic_bezier_path_sampler: mismatch");
      $finish;
   end

   initial begin
      #60000000;
      $display("cubic_bezier_path_sampler: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
